/* rtl/core/stream_prefetch_table_unit_defines.svh */
// ----------------------------------------------------------------------------
// stream prefetch table assertion macros
// shared property shapes for the port-level checks of the prefetch table
// ----------------------------------------------------------------------------
`ifndef STREAM_PREFETCH_TABLE_UNIT_DEFINES_SVH
`define STREAM_PREFETCH_TABLE_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/spt_pkg.sv */
// ----------------------------------------------------------------------------
// spt_pkg
// shared widths, codes and state type of the stream prefetch table
// ----------------------------------------------------------------------------
package spt_pkg;

    localparam int ADDR_W     = 64;
    localparam int DEG_W      = 3;
    localparam int DIST_W     = 7;
    localparam int SPAN_W     = 7;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 7;
    localparam int IN_USER_W  = 3;

    // bit positions inside the input tuser
    localparam int USER_MODE = 0;
    localparam int USER_HIT  = 1;
    localparam int USER_PF   = 2;

    localparam logic MODE_DEMAND = 1'b0;
    localparam logic MODE_FILL   = 1'b1;

    typedef logic [DIR_W-1:0] dir_t;
    localparam dir_t DIR_NONE = 2'd0;
    localparam dir_t DIR_UP   = 2'd1;
    localparam dir_t DIR_DOWN = 2'd2;

    localparam logic [SPAN_W-1:0] SPAN_MAX = 7'd127;

    localparam logic [DEG_W-1:0]  DEG_MIN    = 3'd1;
    localparam logic [DEG_W-1:0]  DEG_MAX    = 3'd4;
    localparam logic [DEG_W-1:0]  DEGREE_RST = 3'd3;
    localparam logic [DIST_W-1:0] DIST_RST   = 7'd8;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_DEGREE   = 4'd0;
    localparam cfg_idx_t CFG_DISTANCE = 4'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRAIN,
        ST_UPDATE,
        ST_EMIT,
        ST_FLUSH
    } state_t;

endpackage

/* rtl/core/spt_ram.sv */
// ----------------------------------------------------------------------------
// spt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module spt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/stream_prefetch_table_unit.sv */
// ----------------------------------------------------------------------------
// stream_prefetch_table_unit
// stream prefetcher over a fifo table of tracked streams held in one ram
// ----------------------------------------------------------------------------
// channel | dir | handshake        | payload
// s       | in  | s_tvalid/tready  | tdata: byte_addr; tuser: mode, was_hit, was_prefetch
// m       | out | m_tvalid/tready  | tdata: pf_line_addr; tlast: last
// cfg     | in  | cfg_valid/ready  | cfg_index, cfg_data (degree, distance)
//
// a fill, a demand hit or a prefetch fill is taken in the idle state without leaving it.
// a demand miss on a nonempty table walks the live entries through the single ram read
// port: train, update, emit degree lines per covering entry, flush; m stalls wait.
// the result register lets the next input in while the final result waits.
// rst_n clears counters, control registers and handshake state; the ram needs no clear.
// ----------------------------------------------------------------------------
module stream_prefetch_table_unit #(
    parameter int TABLE_ENTRIES = 16,
    parameter int BLOCK_BITS    = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [spt_pkg::ADDR_W-1:0]      s_tdata,    // byte_addr
    input  logic [spt_pkg::IN_USER_W-1:0]   s_tuser,    // mode, was_hit, was_prefetch
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [spt_pkg::ADDR_W-1:0]      m_tdata,    // pf_line_addr
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [spt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int BLK_W  = spt_pkg::ADDR_W - BLOCK_BITS;
    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int SPAN_W = spt_pkg::SPAN_W;
    localparam int DIR_W  = spt_pkg::DIR_W;
    localparam int ENT_W  = 2 * BLK_W + DIR_W + SPAN_W;
    localparam int DIR_LO = SPAN_W;
    localparam int WE_LO  = SPAN_W + DIR_W;
    localparam int WS_LO  = SPAN_W + DIR_W + BLK_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W:0]    WRAP_CNT  = (CNT_W + 1)'(TABLE_ENTRIES);

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
    endfunction

    // control state
    spt_pkg::state_t             state_reg, state_next;
    logic [SLOT_W-1:0]           oldest_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [spt_pkg::DEG_W-1:0]   degree_reg;
    logic [spt_pkg::DIST_W-1:0]  distance_reg;
    logic [SLOT_W-1:0]           cur_slot_reg;
    logic [CNT_W-1:0]            left_reg;
    logic [spt_pkg::DEG_W-1:0]   em_idx_reg;
    logic                        hold_valid_reg;
    logic                        out_valid_reg;

    // payload
    logic [BLK_W-1:0]            blk_reg;
    logic [BLK_W-1:0]            t_ws_reg;
    logic [BLK_W-1:0]            t_we_reg;
    spt_pkg::dir_t               t_dir_reg;
    logic [SPAN_W-1:0]           t_span_reg;
    logic [BLK_W-1:0]            em_we_reg;
    spt_pkg::dir_t               em_dir_reg;
    logic [BLK_W-1:0]            hold_blk_reg;
    logic [BLK_W-1:0]            out_blk_reg;
    logic                        out_last_reg;

    // ram
    logic                        ram_wr_en;
    logic [SLOT_W-1:0]           ram_wr_addr;
    logic [ENT_W-1:0]            ram_wr_data;
    logic                        ram_rd_en;
    logic [SLOT_W-1:0]           ram_rd_addr;
    logic [ENT_W-1:0]            ram_rd_data;

    spt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // input decode
    logic             in_fire;
    logic             in_push;
    logic             in_miss;
    logic [BLK_W-1:0] in_blk;
    logic             table_full;
    logic [CNT_W:0]   push_sum;
    logic [CNT_W:0]   push_wrap;
    logic [SLOT_W-1:0] push_slot;

    assign s_tready  = (state_reg == spt_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign in_blk    = s_tdata[spt_pkg::ADDR_W-1:BLOCK_BITS];
    assign in_push   = in_fire && (s_tuser[spt_pkg::USER_MODE] == spt_pkg::MODE_FILL)
                       && !s_tuser[spt_pkg::USER_PF];
    assign in_miss   = in_fire && (s_tuser[spt_pkg::USER_MODE] == spt_pkg::MODE_DEMAND)
                       && !s_tuser[spt_pkg::USER_HIT] && (count_reg != '0);

    assign table_full = (count_reg >= FULL_CNT);
    assign push_sum   = (CNT_W + 1)'(oldest_reg) + (CNT_W + 1)'(count_reg);
    assign push_wrap  = (push_sum >= WRAP_CNT) ? push_sum - WRAP_CNT : push_sum;
    assign push_slot  = table_full ? oldest_reg : push_wrap[SLOT_W-1:0];

    // effective degree
    logic [spt_pkg::DEG_W-1:0] deg_eff;
    assign deg_eff = (degree_reg == '0) ? spt_pkg::DEG_MIN :
                     (degree_reg > spt_pkg::DEG_MAX) ? spt_pkg::DEG_MAX : degree_reg;

    // training of the entry just read
    logic [BLK_W-1:0]  r_ws, r_we;
    spt_pkg::dir_t     r_dir;
    logic [SPAN_W-1:0] r_span;
    logic [BLK_W:0]    delta;
    logic [BLK_W:0]    mag;
    logic              delta_neg;
    logic              delta_nz;
    logic [SPAN_W-1:0] mag_sat;
    logic              up_ok, down_ok;
    logic [BLK_W-1:0]  ws_plus_dist, ws_minus_dist;
    logic [BLK_W-1:0]  tr_we;
    spt_pkg::dir_t     tr_dir;
    logic [SPAN_W-1:0] tr_span;

    assign r_span = ram_rd_data[SPAN_W-1:0];
    assign r_dir  = ram_rd_data[DIR_LO +: DIR_W];
    assign r_we   = ram_rd_data[WE_LO +: BLK_W];
    assign r_ws   = ram_rd_data[WS_LO +: BLK_W];

    assign delta     = {1'b0, blk_reg} - {1'b0, r_ws};
    assign delta_neg = delta[BLK_W];
    assign delta_nz  = (delta != '0);
    assign mag       = delta_neg ? (~delta + (BLK_W + 1)'(1)) : delta;
    assign mag_sat   = (|mag[BLK_W:SPAN_W]) ? spt_pkg::SPAN_MAX : mag[SPAN_W-1:0];
    assign up_ok     = !delta_neg && (mag > (BLK_W + 1)'(r_span))
                       && (mag < (BLK_W + 1)'(distance_reg));
    assign down_ok   = delta_neg && (mag > (BLK_W + 1)'(r_span))
                       && (mag < (BLK_W + 1)'(distance_reg));
    assign ws_plus_dist  = r_ws + BLK_W'(distance_reg);
    assign ws_minus_dist = r_ws - BLK_W'(distance_reg);

    always_comb
    begin
        tr_we   = r_we;
        tr_dir  = r_dir;
        tr_span = r_span;
        if (r_span == '0)
        begin
            // first nonzero delta sets direction and window end
            if (delta_nz)
            begin
                tr_span = mag_sat;
                tr_dir  = delta_neg ? spt_pkg::DIR_DOWN : spt_pkg::DIR_UP;
                tr_we   = delta_neg ? ws_minus_dist : ws_plus_dist;
            end
        end
        else if (((r_dir == spt_pkg::DIR_UP) && up_ok) ||
                 ((r_dir == spt_pkg::DIR_DOWN) && down_ok))
        begin
            tr_span = mag_sat;
            tr_we   = (r_dir == spt_pkg::DIR_UP) ? ws_plus_dist : ws_minus_dist;
        end
        else
        begin
            tr_span = '0;
        end
    end

    // coverage check and window shift of the trained entry
    logic             t_up, t_down;
    logic             emit_hit;
    logic [BLK_W-1:0] deg_ext;
    logic [BLK_W-1:0] ws_step, we_step;
    logic [ENT_W-1:0] wb_data;

    assign t_up     = (t_dir_reg == spt_pkg::DIR_UP);
    assign t_down   = (t_dir_reg == spt_pkg::DIR_DOWN);
    assign emit_hit = (t_up && (blk_reg > t_ws_reg) && (blk_reg <= t_we_reg)) ||
                      (t_down && (blk_reg < t_ws_reg) && (blk_reg >= t_we_reg));
    assign deg_ext  = BLK_W'(deg_eff);
    assign ws_step  = t_up ? t_ws_reg + deg_ext : t_ws_reg - deg_ext;
    assign we_step  = t_up ? t_we_reg + deg_ext : t_we_reg - deg_ext;
    assign wb_data  = emit_hit ? {ws_step, we_step, t_dir_reg, t_span_reg}
                               : {t_ws_reg, t_we_reg, t_dir_reg, t_span_reg};

    // prefetch line of the current emit step
    logic [BLK_W-1:0] em_blk;
    assign em_blk = (em_dir_reg == spt_pkg::DIR_UP) ? em_we_reg + BLK_W'(em_idx_reg)
                                                    : em_we_reg - BLK_W'(em_idx_reg);

    logic out_free;
    logic can_move;
    logic more_entries;
    logic last_step;

    assign out_free     = !out_valid_reg || m_tready;
    assign can_move     = !hold_valid_reg || out_free;
    assign more_entries = (left_reg > CNT_W'(1));
    assign last_step    = (em_idx_reg == deg_eff);

    // control strobes
    logic load_train;
    logic load_emit;
    logic emit_step;
    logic advance;
    logic flush_out;
    logic out_load;

    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = push_slot;
        ram_wr_data = {in_blk, {BLK_W{1'b0}}, spt_pkg::DIR_NONE, {SPAN_W{1'b0}}};
        ram_rd_en   = 1'b0;
        ram_rd_addr = oldest_reg;
        load_train  = 1'b0;
        load_emit   = 1'b0;
        emit_step   = 1'b0;
        advance     = 1'b0;
        flush_out   = 1'b0;
        unique case (state_reg)
            spt_pkg::ST_IDLE:
            begin
                ram_wr_en = in_push;
                ram_rd_en = in_miss;
            end
            spt_pkg::ST_TRAIN:
            begin
                load_train = 1'b1;
            end
            spt_pkg::ST_UPDATE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = cur_slot_reg;
                ram_wr_data = wb_data;
                if (emit_hit)
                begin
                    load_emit = 1'b1;
                end
                else
                begin
                    advance = more_entries;
                end
            end
            spt_pkg::ST_EMIT:
            begin
                emit_step = can_move;
                advance   = can_move && last_step && more_entries;
            end
            spt_pkg::ST_FLUSH:
            begin
                flush_out = hold_valid_reg && out_free;
            end
            default:
            begin
                load_train = 1'b0;
            end
        endcase
        if (advance)
        begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = slot_inc(cur_slot_reg);
        end
    end

    assign out_load = (emit_step && hold_valid_reg) || flush_out;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spt_pkg::ST_IDLE:
            begin
                if (in_miss)
                begin
                    state_next = spt_pkg::ST_TRAIN;
                end
            end
            spt_pkg::ST_TRAIN:
            begin
                state_next = spt_pkg::ST_UPDATE;
            end
            spt_pkg::ST_UPDATE:
            begin
                if (emit_hit)
                begin
                    state_next = spt_pkg::ST_EMIT;
                end
                else if (more_entries)
                begin
                    state_next = spt_pkg::ST_TRAIN;
                end
                else
                begin
                    state_next = spt_pkg::ST_FLUSH;
                end
            end
            spt_pkg::ST_EMIT:
            begin
                if (can_move && last_step)
                begin
                    state_next = more_entries ? spt_pkg::ST_TRAIN : spt_pkg::ST_FLUSH;
                end
            end
            spt_pkg::ST_FLUSH:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    state_next = spt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spt_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spt_pkg::ST_IDLE;
            oldest_reg     <= '0;
            count_reg      <= '0;
            degree_reg     <= spt_pkg::DEGREE_RST;
            distance_reg   <= spt_pkg::DIST_RST;
            cur_slot_reg   <= '0;
            left_reg       <= '0;
            em_idx_reg     <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == spt_pkg::CFG_DEGREE)
                begin
                    degree_reg <= cfg_data[spt_pkg::DEG_W-1:0];
                end
                else if (cfg_index == spt_pkg::CFG_DISTANCE)
                begin
                    distance_reg <= cfg_data[spt_pkg::DIST_W-1:0];
                end
            end
            if (in_push)
            begin
                // a full table replaces its oldest entry
                if (table_full)
                begin
                    oldest_reg <= slot_inc(oldest_reg);
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (in_miss)
            begin
                cur_slot_reg <= oldest_reg;
                left_reg     <= count_reg;
            end
            else if (advance)
            begin
                cur_slot_reg <= slot_inc(cur_slot_reg);
                left_reg     <= left_reg - CNT_W'(1);
            end
            if (load_emit)
            begin
                em_idx_reg <= spt_pkg::DEG_MIN;
            end
            else if (emit_step)
            begin
                em_idx_reg <= em_idx_reg + spt_pkg::DEG_W'(1);
            end
            // newest line waits in the hold stage until the next one shows up or the flush sends it
            if (emit_step)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (flush_out)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            blk_reg <= in_blk;
        end
        if (load_train)
        begin
            t_ws_reg   <= r_ws;
            t_we_reg   <= tr_we;
            t_dir_reg  <= tr_dir;
            t_span_reg <= tr_span;
        end
        if (load_emit)
        begin
            em_we_reg  <= t_we_reg;
            em_dir_reg <= t_dir_reg;
        end
        if (emit_step)
        begin
            hold_blk_reg <= em_blk;
        end
        if (out_load)
        begin
            out_blk_reg  <= hold_blk_reg;
            out_last_reg <= flush_out;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_blk_reg, {BLOCK_BITS{1'b0}}};
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/core/spt_sva.sv */
// ----------------------------------------------------------------------------
// spt_sva
// port-level checks of the stream prefetch table, bound to the top level
// ----------------------------------------------------------------------------
`include "stream_prefetch_table_unit_defines.svh"

module spt_sva (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [spt_pkg::IN_USER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [spt_pkg::ADDR_W-1:0]    m_tdata,
    input logic                          m_tlast
);

    logic s_fire;
    logic fill_fire;
    logic hit_fire;

    assign s_fire    = s_tvalid && s_tready;
    assign fill_fire = s_fire && (s_tuser[spt_pkg::USER_MODE] == spt_pkg::MODE_FILL);
    assign hit_fire  = s_fire && (s_tuser[spt_pkg::USER_MODE] == spt_pkg::MODE_DEMAND)
                       && s_tuser[spt_pkg::USER_HIT];

    // a stalled result keeps its payload
    `SPT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // fills never start a table walk
    `SPT_ASSERT_NEXT(a_fill_single, clk, rst_n, fill_fire, s_tready, "fill transfer blocked the input")

    // demand hits never start a table walk
    `SPT_ASSERT_NEXT(a_hit_single, clk, rst_n, hit_fire, s_tready, "hit transfer blocked the input")

    // a non-final result means the walk of its input is still running
    `SPT_ASSERT_NOW(a_run_busy, clk, rst_n, m_tvalid && !m_tlast, !s_tready, "input taken before the final result")

endmodule

bind stream_prefetch_table_unit spt_sva u_spt_sva (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
